FILE: rtl/core/encrect_pkg.sv
// ----------------------------------------------------------------------------
// encrect_pkg
// Shared types and constants for the half-plane enclosing rectangle block.
// ----------------------------------------------------------------------------
package encrect_pkg;

    // coordinate width, signed Q16.8 at the default
    localparam int COORD_BITS = 24;
    // fractional bits of the coordinate format
    localparam int FRAC_BITS  = 8;
    // width of the area result, unsigned Q32.16
    localparam int AREA_BITS  = 48;

    // divider runs one quotient bit per cycle
    localparam int DIV_STEPS  = COORD_BITS;
    localparam int CNT_BITS   = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUERY_X = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUERY_Y = 1'b1;

    // bit positions in the bound valid vector
    localparam int SEEN_LEFT  = 0;
    localparam int SEEN_RIGHT = 1;
    localparam int SEEN_LOWER = 2;
    localparam int SEEN_UPPER = 3;

    // one half-plane
    typedef struct packed {
        logic                         bounds_y;
        logic signed [COORD_BITS-1:0] coef_a;
        logic signed [COORD_BITS-1:0] coef_b;
        logic                         last;
    } item_t;

    // one result
    typedef struct packed {
        logic                 found;
        logic [AREA_BITS-1:0] area;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic test;
        logic div_start;
        logic div_step;
        logic update;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic contained;
        logic last;
    } dp_status_t;

endpackage

FILE: rtl/core/encrect_dp.sv
// ----------------------------------------------------------------------------
// encrect_dp
// Datapath: query registers, item latch, containment test, serial divider
// for the boundary line, bound registers and result register.
// ----------------------------------------------------------------------------
module encrect_dp (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_wr_en,
    input  logic [encrect_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [encrect_pkg::COORD_BITS-1:0]         cfg_data,
    input  encrect_pkg::item_t                         item,
    input  encrect_pkg::dp_cmd_t                       cmd,
    output encrect_pkg::dp_status_t                    status,
    output encrect_pkg::result_t                       result
);

    localparam int C = encrect_pkg::COORD_BITS;
    localparam int F = encrect_pkg::FRAC_BITS;
    localparam logic signed [C-1:0] COORD_MAX = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] COORD_MIN = {1'b1, {(C-1){1'b0}}};
    localparam logic [C-1:0]        NEG_LIMIT = {1'b1, {(C-1){1'b0}}};

    // query point
    logic signed [C-1:0] qx_reg, qy_reg;

    // latched item
    logic                on_y_reg;
    logic signed [C-1:0] a_reg, b_reg;
    logic                last_reg;

    // containment and divider
    logic                contained_reg;
    logic [C-1:0]        rem_reg, rem_next;
    logic [C-1:0]        quo_reg, quo_next;
    logic                ovf_reg;
    logic                neg_reg;

    // bounds
    logic signed [C-1:0] left_reg, right_reg, lower_reg, upper_reg;
    logic [3:0]          seen_reg;

    // result register
    encrect_pkg::result_t result_reg;

    // query coordinate for the current axis
    logic signed [C-1:0] q_sel;
    assign q_sel = on_y_reg ? qy_reg : qx_reg;

    // exact a*q + b*256 in signed Q33.16
    logic signed [2*C-1:0] prod;
    logic signed [C+F-1:0] b_scaled;
    logic signed [2*C:0]   lhs;
    assign prod     = a_reg * q_sel;
    assign b_scaled = $signed({b_reg, {F{1'b0}}});
    assign lhs      = (2*C+1)'(prod) + (2*C+1)'(b_scaled);

    // operand magnitudes for the divider
    logic [C-1:0]   a_u, b_u, a_mag, b_mag;
    logic [C+F-1:0] num;
    logic           div_ovf;
    assign a_u     = a_reg;
    assign b_u     = b_reg;
    assign a_mag   = a_u[C-1] ? (~a_u + 1'b1) : a_u;
    assign b_mag   = b_u[C-1] ? (~b_u + 1'b1) : b_u;
    assign num     = {b_mag, {F{1'b0}}};
    // quotient does not fit in C bits
    assign div_ovf = (2*C)'(num) >= {a_mag, {C{1'b0}}};

    // restoring divide step
    logic [C:0] trial, diff;
    logic       ge;
    assign trial    = {rem_reg, quo_reg[C-1]};
    assign diff     = trial - {1'b0, a_mag};
    assign ge       = trial >= {1'b0, a_mag};
    assign rem_next = ge ? diff[C-1:0] : trial[C-1:0];
    assign quo_next = {quo_reg[C-2:0], ge};

    // signed boundary, truncated toward zero and saturated
    logic signed [C-1:0] line;
    always_comb
    begin
        if (!neg_reg)
        begin
            if (ovf_reg || quo_reg[C-1])
                line = COORD_MAX;
            else
                line = $signed(quo_reg);
        end
        else
        begin
            if (ovf_reg || (quo_reg > NEG_LIMIT))
                line = COORD_MIN;
            else
                line = $signed(~quo_reg + 1'b1);
        end
    end

    logic line_lt, line_gt;
    assign line_lt = line < q_sel;
    assign line_gt = line > q_sel;

    // rectangle area
    logic                 found;
    logic [C:0]           width_x, height_y;
    logic [2*C+1:0]       area_full;
    assign found     = &seen_reg;
    assign width_x   = (C+1)'($signed(right_reg)) - (C+1)'($signed(left_reg));
    assign height_y  = (C+1)'($signed(upper_reg)) - (C+1)'($signed(lower_reg));
    assign area_full = width_x * height_y;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == encrect_pkg::REG_QUERY_X)
                qx_reg <= $signed(cfg_data);
            if (cfg_index == encrect_pkg::REG_QUERY_Y)
                qy_reg <= $signed(cfg_data);
        end
    end

    // item latch, containment, divider and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            on_y_reg <= item.bounds_y;
            a_reg    <= item.coef_a;
            b_reg    <= item.coef_b;
            last_reg <= item.last;
        end
        if (cmd.test)
            contained_reg <= lhs[2*C] && (a_reg != '0);
        if (cmd.div_start)
        begin
            rem_reg <= C'(num[C+F-1:C]);
            quo_reg <= num[C-1:0];
            ovf_reg <= div_ovf;
            neg_reg <= a_u[C-1] ~^ b_u[C-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.emit)
        begin
            result_reg.found <= found;
            result_reg.area  <= found ? encrect_pkg::AREA_BITS'(area_full) : '0;
        end
    end

    // bound registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            lower_reg <= '0;
            upper_reg <= '0;
            seen_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            lower_reg <= '0;
            upper_reg <= '0;
            seen_reg  <= '0;
        end
        else if (cmd.update)
        begin
            if (!on_y_reg)
            begin
                if (line_lt && (!seen_reg[encrect_pkg::SEEN_LEFT] || line > left_reg))
                begin
                    left_reg                         <= line;
                    seen_reg[encrect_pkg::SEEN_LEFT] <= 1'b1;
                end
                if (line_gt && (!seen_reg[encrect_pkg::SEEN_RIGHT] || line < right_reg))
                begin
                    right_reg                         <= line;
                    seen_reg[encrect_pkg::SEEN_RIGHT] <= 1'b1;
                end
            end
            else
            begin
                if (line_lt && (!seen_reg[encrect_pkg::SEEN_LOWER] || line > lower_reg))
                begin
                    lower_reg                         <= line;
                    seen_reg[encrect_pkg::SEEN_LOWER] <= 1'b1;
                end
                if (line_gt && (!seen_reg[encrect_pkg::SEEN_UPPER] || line < upper_reg))
                begin
                    upper_reg                         <= line;
                    seen_reg[encrect_pkg::SEEN_UPPER] <= 1'b1;
                end
            end
        end
    end

    assign status.contained = contained_reg;
    assign status.last      = last_reg;
    assign result           = result_reg;

endmodule

FILE: rtl/core/encrect_ctrl.sv
// ----------------------------------------------------------------------------
// encrect_ctrl
// Controller: sequences item intake, containment test, serial divide,
// bound update and result hand-off; owns both handshakes.
// ----------------------------------------------------------------------------
module encrect_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    output logic                        result_valid,
    input  logic                        result_stall,
    input  encrect_pkg::dp_status_t     status,
    output encrect_pkg::dp_cmd_t        cmd
);

    localparam int CB = encrect_pkg::CNT_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_TEST = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam logic [CB-1:0] CNT_LAST = CB'(encrect_pkg::DIV_STEPS - 1);

    logic [2:0]    state_reg, state_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic          valid_reg, valid_next;
    logic          out_free;

    assign out_free   = !valid_reg || !result_stall;
    assign item_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.test   = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                priority if (status.contained)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
                else if (status.last)
                    state_next = ST_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = status.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid
    always_comb
    begin
        if (cmd.emit)
            valid_next = 1'b1;
        else if (!result_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg;

`ifndef ASSERT_OFF
    // an accepted transaction always starts the containment test
    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == ST_MUL))
        else $error("accepted transaction did not enter the test sequence");

    // a result only appears out of the emit state
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == ST_EMIT))
        else $error("result valid rose outside of emit");

    // emit never overwrites a stalled result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!valid_reg || !result_stall))
        else $error("emit while a stalled result is pending");

    // divider step count stays in range
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg <= CNT_LAST))
        else $error("divider step count out of range");
`endif

endmodule

FILE: rtl/core/enclosing_rectangle_from_halfplanes.sv
// A contained half-plane runs from its accepting edge to the next accept through
// test, a divide of COORD_BITS = 24 bits at one bit per cycle, update and intake.
// A half-plane missing the point, or with a zero coefficient, skips divide and update.
// A last item ends in emit; its result is valid the cycle after emit.
// The serial divider sets the rate; one transaction is in flight at a time.
// Reset (rst_n low, asynchronous) clears the query point, all bounds and valids.
// ----------------------------------------------------------------------------
// enclosing_rectangle_from_halfplanes
// Top level: tightest axis-aligned rectangle around a query point from a
// stream of half-planes, with its area reported on the last item.
// ----------------------------------------------------------------------------
module enclosing_rectangle_from_halfplanes (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [encrect_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [encrect_pkg::COORD_BITS-1:0]     cfg_data,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  encrect_pkg::item_t                     item,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output encrect_pkg::result_t                   result
);

    encrect_pkg::dp_cmd_t    cmd;
    encrect_pkg::dp_status_t status;

    // sequencing and handshakes
    encrect_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // arithmetic and state
    encrect_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
